### hdl/fcdpr_pkg.sv
// Shared types, constants and helpers for the four-channel double-pulse release block.
// No dependencies; used by every other module in the block by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package fcdpr_pkg;

    // Number of output channels and field widths.
    localparam int NUM_CH      = 4;
    localparam int TIME_W      = 32;
    localparam int INTERVAL_W  = 16;
    localparam int TRIG_W      = 8;
    localparam int NUM_REQ     = 8;

    // Register reset values.
    localparam logic [INTERVAL_W-1:0] OPEN_RESET  = 16'd100;
    localparam logic [INTERVAL_W-1:0] CLOSE_RESET = 16'd100;

    // Configuration register indexes.
    localparam logic CFG_OPEN_IDX  = 1'b0;
    localparam logic CFG_CLOSE_IDX = 1'b1;

    // Per-channel status handed from a channel sequencer to the top level.
    typedef struct packed {
        logic pin_next;   // level after the current tick
        logic busy_next;  // busy flag after the current tick
        logic pin_cur;    // level held before the current tick
    } chan_status_t;

    // One result transaction.
    typedef struct packed {
        logic [NUM_CH-1:0] pin_levels;
        logic [NUM_CH-1:0] busy_mask;
    } result_t;

    // Request bits in order: front, rear, left, right, ch1, ch2, ch3, ch4.
    // Returns the set of channels to arm; bit i is channel i+1.
    function automatic logic [NUM_CH-1:0] arm_mask(input logic [NUM_REQ-1:0] req);
        logic [NUM_CH-1:0] m;
        m = '0;
        if (req[0]) m = m | 4'b0011;
        if (req[1]) m = m | 4'b1100;
        if (req[2]) m = m | 4'b0101;
        if (req[3]) m = m | 4'b1010;
        if (req[4]) m = m | 4'b0001;
        if (req[5]) m = m | 4'b0010;
        if (req[6]) m = m | 4'b0100;
        if (req[7]) m = m | 4'b1000;
        return m;
    endfunction

endpackage

`default_nettype wire

### hdl/fcdpr_channel.sv
// One channel's double-pulse sequencer: phase, phase start time and pin level.
// Depends on fcdpr_pkg for widths and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module fcdpr_channel
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 tick,
    input  wire logic                                 arm,
    input  wire logic [fcdpr_pkg::TIME_W-1:0]         now_ms,
    input  wire logic [fcdpr_pkg::INTERVAL_W-1:0]     open_ms,
    input  wire logic [fcdpr_pkg::INTERVAL_W-1:0]     close_ms,
    output fcdpr_pkg::chan_status_t                   status
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ARMED = 3'd1,
        PH_HIGH1 = 3'd2,
        PH_GAP   = 3'd3,
        PH_HIGH2 = 3'd4,
        PH_DONE  = 3'd5
    } phase_t;

    phase_t                          phase_reg, phase_next, phase_cur;
    logic [fcdpr_pkg::TIME_W-1:0]    start_reg, start_next;
    logic                            pin_reg, pin_next;
    logic [fcdpr_pkg::TIME_W-1:0]    elapsed;
    logic                            open_done, close_done;

    // Elapsed time wraps modulo 2^32; intervals are zero-extended for the compare.
    assign elapsed    = now_ms - start_reg;
    assign open_done  = elapsed >= {{(fcdpr_pkg::TIME_W-fcdpr_pkg::INTERVAL_W){1'b0}}, open_ms};
    assign close_done = elapsed >= {{(fcdpr_pkg::TIME_W-fcdpr_pkg::INTERVAL_W){1'b0}}, close_ms};

    // Arming restarts the channel from the armed phase, even mid-sequence.
    assign phase_cur = arm ? PH_ARMED : phase_reg;

    // Advance by at most one phase per enabled tick.
    always_comb
    begin
        phase_next = phase_reg;
        start_next = start_reg;
        pin_next   = pin_reg;
        if (tick)
        begin
            phase_next = phase_cur;
            case (phase_cur)
                PH_ARMED:
                begin
                    pin_next   = 1'b1;
                    phase_next = PH_HIGH1;
                    start_next = now_ms;
                end
                PH_HIGH1:
                begin
                    if (open_done)
                    begin
                        pin_next   = 1'b0;
                        phase_next = PH_GAP;
                        start_next = now_ms;
                    end
                end
                PH_GAP:
                begin
                    if (close_done)
                    begin
                        pin_next   = 1'b1;
                        phase_next = PH_HIGH2;
                        start_next = now_ms;
                    end
                end
                PH_HIGH2:
                begin
                    if (open_done)
                    begin
                        pin_next   = 1'b0;
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = phase_cur;
                end
            endcase
        end
    end

    // State and pin register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            start_reg <= '0;
            pin_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            start_reg <= start_next;
            pin_reg   <= pin_next;
        end
    end

    // Status after this tick; busy spans armed through the second high phase.
    assign status.pin_next  = pin_next;
    assign status.busy_next = (phase_next == PH_ARMED) || (phase_next == PH_HIGH1) ||
                              (phase_next == PH_GAP)   || (phase_next == PH_HIGH2);
    assign status.pin_cur   = pin_reg;

endmodule

`default_nettype wire

### hdl/fcdpr_out_buf.sv
// Two-entry result buffer that decouples the result channel from the processing stage.
// Depends on fcdpr_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none

module fcdpr_out_buf
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire fcdpr_pkg::result_t   wr_data,
    output logic                      has_room,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output fcdpr_pkg::result_t        rd_data,
    output logic [1:0]                count
);

    fcdpr_pkg::result_t  mem_reg [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;
    logic                rd_en;

    assign rd_en     = out_valid && out_ready;
    assign has_room  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign rd_data   = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage carries no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### hdl/four_channel_double_pulse_release.sv
// Top level of the four-channel double-pulse release sequencer.
// Depends on fcdpr_pkg, fcdpr_channel and fcdpr_out_buf.
//
//  Channel | Handshake              | Carries
//  --------+------------------------+---------------------------------------------
//  input   | in_valid / in_ready    | enable, eight request bits, trigger_seq, now_ms
//  result  | out_valid / out_ready  | pin_levels, busy_mask
//  config  | cfg_valid / cfg_ready  | cfg_index, cfg_data (open and close intervals)
//
// One transaction is accepted per cycle while the result buffer has room: it is captured
// in an input register, processed against the channel state once the buffer has room and
// written to a two-entry result buffer, so a result passes the input register and then
// the result buffer before out_valid shows it.
// The input register stalls only when the result buffer is full.
// Reset returns every channel to idle with its pin low and both intervals to 100 ms.
// Configuration writes are taken in every cycle.
`timescale 1ns / 1ps
`default_nettype none

module four_channel_double_pulse_release
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  enable,
    input  wire logic                                  front_req,
    input  wire logic                                  rear_req,
    input  wire logic                                  left_req,
    input  wire logic                                  right_req,
    input  wire logic                                  ch1_req,
    input  wire logic                                  ch2_req,
    input  wire logic                                  ch3_req,
    input  wire logic                                  ch4_req,
    input  wire logic [fcdpr_pkg::TRIG_W-1:0]          trigger_seq,
    input  wire logic [fcdpr_pkg::TIME_W-1:0]          now_ms,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [fcdpr_pkg::NUM_CH-1:0]               pin_levels,
    output logic [fcdpr_pkg::NUM_CH-1:0]               busy_mask,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic                                  cfg_index,
    input  wire logic [fcdpr_pkg::INTERVAL_W-1:0]      cfg_data
);

    logic                                   s1_valid_reg;
    logic                                   s1_en_reg;
    logic [fcdpr_pkg::NUM_REQ-1:0]          s1_req_reg;
    logic [fcdpr_pkg::TRIG_W-1:0]           s1_trig_reg;
    logic [fcdpr_pkg::TIME_W-1:0]           s1_now_reg;
    logic                                   s1_fire;
    logic                                   in_fire;
    logic                                   buf_room;
    logic [1:0]                             buf_count;

    logic [fcdpr_pkg::TRIG_W-1:0]           last_trig_reg, last_trig_next;
    logic [fcdpr_pkg::INTERVAL_W-1:0]       open_reg, close_reg;
    logic                                   tick;
    logic                                   trig_changed;
    logic [fcdpr_pkg::NUM_CH-1:0]           arm;
    logic [fcdpr_pkg::NUM_CH-1:0]           pin_cur;
    fcdpr_pkg::chan_status_t                ch_status [fcdpr_pkg::NUM_CH];
    fcdpr_pkg::result_t                     result;
    fcdpr_pkg::result_t                     rd_data;

    // Input register handshake: refills whenever it is empty or being processed.
    assign s1_fire   = s1_valid_reg && buf_room;
    assign in_ready  = !s1_valid_reg || s1_fire;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input payload carries no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_en_reg   <= enable;
            s1_req_reg  <= {ch4_req, ch3_req, ch2_req, ch1_req,
                            right_req, left_req, rear_req, front_req};
            s1_trig_reg <= trigger_seq;
            s1_now_reg  <= now_ms;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= fcdpr_pkg::OPEN_RESET;
            close_reg <= fcdpr_pkg::CLOSE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fcdpr_pkg::CFG_OPEN_IDX:  open_reg  <= cfg_data;
                fcdpr_pkg::CFG_CLOSE_IDX: close_reg <= cfg_data;
                default:                  open_reg  <= open_reg;
            endcase
        end
    end

    // Trigger detection: on an enabled tick, a changed byte applies the request bits and is stored.
    assign tick           = s1_fire && s1_en_reg;
    assign trig_changed   = s1_trig_reg != last_trig_reg;
    assign arm            = (tick && trig_changed) ? fcdpr_pkg::arm_mask(s1_req_reg) : '0;
    assign last_trig_next = (tick && trig_changed) ? s1_trig_reg : last_trig_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_trig_reg <= '0;
        end
        else
        begin
            last_trig_reg <= last_trig_next;
        end
    end

    // One sequencer per channel.
    for (genvar c = 0; c < fcdpr_pkg::NUM_CH; c++)
    begin : g_ch
        fcdpr_channel u_channel
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .tick     (tick),
            .arm      (arm[c]),
            .now_ms   (s1_now_reg),
            .open_ms  (open_reg),
            .close_ms (close_reg),
            .status   (ch_status[c])
        );

        assign result.pin_levels[c] = ch_status[c].pin_next;
        assign result.busy_mask[c]  = ch_status[c].busy_next;
        assign pin_cur[c]           = ch_status[c].pin_cur;
    end

    // Result buffer.
    fcdpr_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (s1_fire),
        .wr_data   (result),
        .has_room  (buf_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rd_data   (rd_data),
        .count     (buf_count)
    );

    assign pin_levels = rd_data.pin_levels;
    assign busy_mask  = rd_data.busy_mask;

`ifndef SYNTHESIS
    // A pin is only ever high while its channel is busy.
    a_pin_implies_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((pin_levels & ~busy_mask) == '0))
        else $error("pin high on a channel that is not busy");

    // A disabled tick leaves every pin and the stored trigger untouched.
    a_disabled_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !s1_en_reg) |=> ($stable(pin_cur) && $stable(last_trig_reg)))
        else $error("state changed on a disabled tick");

    // The result buffer never holds more than two transactions.
    a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (buf_count != 2'd3))
        else $error("result buffer overflow");

    // No processing while the result buffer is full.
    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (buf_count == 2'd2) |-> !s1_fire)
        else $error("result written into a full buffer");
`endif

endmodule

`default_nettype wire

### dv/four_channel_double_pulse_release_test.sv
// Self-checking testbench for the four-channel double-pulse release sequencer.
// Depends on fcdpr_pkg and four_channel_double_pulse_release; a directed table runs first,
// then randomised pulse sequences under several interval settings.
`timescale 1ns / 1ps

module four_channel_double_pulse_release_test;

    localparam int  ITEMS_PER_PHASE = 225;
    localparam int  NUM_PHASES      = 8;
    localparam int  SETTLE_CYCLES   = 4;
    localparam int  DRAIN_LIMIT     = 2000;
    localparam int  HOLDOFF_CYCLES  = 150;
    localparam time TIMEOUT_NS      = 5_000_000;

    // Request bits in the order front, rear, left, right, ch1 .. ch4 (MSB first).
    localparam logic [7:0] REQ_NONE  = 8'b0000_0000;
    localparam logic [7:0] REQ_FRONT = 8'b1000_0000;
    localparam logic [7:0] REQ_REAR  = 8'b0100_0000;
    localparam logic [7:0] REQ_LEFT  = 8'b0010_0000;
    localparam logic [7:0] REQ_RIGHT = 8'b0001_0000;
    localparam logic [7:0] REQ_CH1   = 8'b0000_1000;
    localparam logic [7:0] REQ_CH2   = 8'b0000_0100;
    localparam logic [7:0] REQ_CH3   = 8'b0000_0010;
    localparam logic [7:0] REQ_CH4   = 8'b0000_0001;
    localparam logic [7:0] REQ_ALL   = 8'b1111_1111;

    typedef enum logic [2:0] {
        CH_IDLE        = 3'd0,
        CH_ARMED       = 3'd1,
        CH_FIRST_HIGH  = 3'd2,
        CH_GAP         = 3'd3,
        CH_SECOND_HIGH = 3'd4,
        CH_DONE        = 3'd5
    } chan_phase_t;

    typedef struct packed {
        logic                             enable;
        logic [7:0]                       req;
        logic [fcdpr_pkg::TRIG_W-1:0]     trigger_seq;
        logic [fcdpr_pkg::TIME_W-1:0]     now_ms;
    } tick_t;

    typedef enum logic {ROW_TICK, ROW_CONFIG} row_kind_t;

    typedef struct {
        row_kind_t                           kind;
        tick_t                               tick;
        bit                                  known;
        fcdpr_pkg::result_t                  want_res;
        logic [fcdpr_pkg::INTERVAL_W-1:0]    open_v;
        logic [fcdpr_pkg::INTERVAL_W-1:0]    close_v;
    } plan_row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    tick_t                               drv;
    bit                                  drv_known;
    fcdpr_pkg::result_t                  drv_want;
    logic                                out_valid;
    logic                                out_ready;
    logic [fcdpr_pkg::NUM_CH-1:0]        pin_levels;
    logic [fcdpr_pkg::NUM_CH-1:0]        busy_mask;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic                                cfg_index;
    logic [fcdpr_pkg::INTERVAL_W-1:0]    cfg_data;

    // Predicted sequencer state.
    logic [fcdpr_pkg::INTERVAL_W-1:0]    model_open;
    logic [fcdpr_pkg::INTERVAL_W-1:0]    model_close;
    logic [fcdpr_pkg::TRIG_W-1:0]        model_last_trig;
    chan_phase_t                         model_phase [fcdpr_pkg::NUM_CH];
    logic [fcdpr_pkg::TIME_W-1:0]        model_start [fcdpr_pkg::NUM_CH];
    logic [fcdpr_pkg::NUM_CH-1:0]        model_pins;

    fcdpr_pkg::result_t                  pending_pin_states [$];
    plan_row_t                           plan [$];

    // Random stream state and process coordination.
    logic [fcdpr_pkg::TIME_W-1:0]        clock_ms;
    logic [fcdpr_pkg::TRIG_W-1:0]        trig_seq;
    bit                                  no_idle;
    int                                  holdoff_cycles;
    int                                  fail_count;
    int                                  tick_count;
    int                                  result_count;
    int                                  cfg_count;
    int                                  holdoff_count;

    four_channel_double_pulse_release dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .enable      (drv.enable),
        .front_req   (drv.req[7]),
        .rear_req    (drv.req[6]),
        .left_req    (drv.req[5]),
        .right_req   (drv.req[4]),
        .ch1_req     (drv.req[3]),
        .ch2_req     (drv.req[2]),
        .ch3_req     (drv.req[1]),
        .ch4_req     (drv.req[0]),
        .trigger_seq (drv.trigger_seq),
        .now_ms      (drv.now_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pin_levels  (pin_levels),
        .busy_mask   (busy_mask),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout after %0t with %0d results outstanding", $time,
                 pending_pin_states.size());
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        fail_count++;
        $display("MISMATCH at %0t, result %0d: %s got 0x%0h expected 0x%0h",
                 $time, result_count, what, got, want);
    endtask

    // Advances the predicted channel state by one service tick and returns the result.
    function automatic fcdpr_pkg::result_t advance_channels(tick_t t);
        logic [fcdpr_pkg::NUM_CH-1:0] arm;
        logic [fcdpr_pkg::TIME_W-1:0] elapsed;
        fcdpr_pkg::result_t           r;
        int                           c;
        if (t.enable)
        begin
            // A fresh trigger byte applies the requests and is remembered.
            if (t.trigger_seq != model_last_trig)
            begin
                arm = '0;
                if (t.req[7]) arm = arm | 4'b0011;
                if (t.req[6]) arm = arm | 4'b1100;
                if (t.req[5]) arm = arm | 4'b0101;
                if (t.req[4]) arm = arm | 4'b1010;
                if (t.req[3]) arm = arm | 4'b0001;
                if (t.req[2]) arm = arm | 4'b0010;
                if (t.req[1]) arm = arm | 4'b0100;
                if (t.req[0]) arm = arm | 4'b1000;
                for (c = 0; c < fcdpr_pkg::NUM_CH; c++)
                begin
                    if (arm[c])
                        model_phase[c] = CH_ARMED;
                end
                model_last_trig = t.trigger_seq;
            end
            // Each channel moves on by at most one phase, timed by wrapping subtraction.
            for (c = 0; c < fcdpr_pkg::NUM_CH; c++)
            begin
                elapsed = t.now_ms - model_start[c];
                case (model_phase[c])
                    CH_ARMED:
                    begin
                        model_pins[c]  = 1'b1;
                        model_phase[c] = CH_FIRST_HIGH;
                        model_start[c] = t.now_ms;
                    end
                    CH_FIRST_HIGH:
                    begin
                        if (elapsed >= {16'd0, model_open})
                        begin
                            model_pins[c]  = 1'b0;
                            model_phase[c] = CH_GAP;
                            model_start[c] = t.now_ms;
                        end
                    end
                    CH_GAP:
                    begin
                        if (elapsed >= {16'd0, model_close})
                        begin
                            model_pins[c]  = 1'b1;
                            model_phase[c] = CH_SECOND_HIGH;
                            model_start[c] = t.now_ms;
                        end
                    end
                    CH_SECOND_HIGH:
                    begin
                        if (elapsed >= {16'd0, model_open})
                        begin
                            model_pins[c]  = 1'b0;
                            model_phase[c] = CH_DONE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        r.pin_levels = model_pins;
        for (c = 0; c < fcdpr_pkg::NUM_CH; c++)
            r.busy_mask[c] = (model_phase[c] >= CH_ARMED) &&
                             (model_phase[c] <= CH_SECOND_HIGH);
        return r;
    endfunction

    // Scoreboard: predicts on every accepted tick and checks every accepted result.
    always @(posedge clk)
    begin : scoreboard
        fcdpr_pkg::result_t want;
        fcdpr_pkg::result_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_count++;
                if (cfg_index == fcdpr_pkg::CFG_OPEN_IDX)
                    model_open = cfg_data;
                else
                    model_close = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                tick_count++;
                want = advance_channels(drv);
                if (drv_known)
                    want = drv_want;
                pending_pin_states.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                got.pin_levels = pin_levels;
                got.busy_mask  = busy_mask;
                result_count++;
                if (pending_pin_states.size() == 0)
                begin
                    report_mismatch("result with nothing outstanding", 32'(got), 32'd0);
                end
                else
                begin
                    want = pending_pin_states.pop_front();
                    if (got.pin_levels !== want.pin_levels)
                        report_mismatch("pin_levels", 32'(got.pin_levels),
                                        32'(want.pin_levels));
                    if (got.busy_mask !== want.busy_mask)
                        report_mismatch("busy_mask", 32'(got.busy_mask),
                                        32'(want.busy_mask));
                end
            end
        end
    end

    // Result sink: random back-pressure, plus a long hold-off on request.
    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (holdoff_cycles > 0)
            begin
                stall          = holdoff_cycles;
                holdoff_cycles = 0;
                holdoff_count++;
            end
            else
            begin
                stall = no_idle ? 0 : $urandom_range(0, 8);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Offers one tick transaction after a random gap; valid is left high on return.
    task automatic offer_tick(tick_t t, bit known, fcdpr_pkg::result_t want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        drv       <= t;
        drv_known <= known;
        drv_want  <= want;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stops offering and waits until every expected result has been taken or the limit runs out.
    task automatic wait_for_results(int limit);
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (pending_pin_states.size() != 0 && waited < limit);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both interval registers back to back, keeping valid high between them.
    task automatic write_intervals(logic [fcdpr_pkg::INTERVAL_W-1:0] open_v,
                                   logic [fcdpr_pkg::INTERVAL_W-1:0] close_v);
        cfg_valid <= 1'b1;
        cfg_index <= fcdpr_pkg::CFG_OPEN_IDX;
        cfg_data  <= open_v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= fcdpr_pkg::CFG_CLOSE_IDX;
        cfg_data  <= close_v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic plan_row_t tick_row(logic en, logic [7:0] req,
                                           logic [fcdpr_pkg::TRIG_W-1:0] trig,
                                           logic [fcdpr_pkg::TIME_W-1:0] now_v);
        plan_row_t row;
        row.kind             = ROW_TICK;
        row.tick.enable      = en;
        row.tick.req         = req;
        row.tick.trigger_seq = trig;
        row.tick.now_ms      = now_v;
        row.known            = 1'b0;
        row.want_res         = '0;
        row.open_v           = '0;
        row.close_v          = '0;
        return row;
    endfunction

    function automatic plan_row_t known_row(logic en, logic [7:0] req,
                                            logic [fcdpr_pkg::TRIG_W-1:0] trig,
                                            logic [fcdpr_pkg::TIME_W-1:0] now_v,
                                            logic [fcdpr_pkg::NUM_CH-1:0] pins,
                                            logic [fcdpr_pkg::NUM_CH-1:0] busy);
        plan_row_t row;
        row                     = tick_row(en, req, trig, now_v);
        row.known               = 1'b1;
        row.want_res.pin_levels = pins;
        row.want_res.busy_mask  = busy;
        return row;
    endfunction

    function automatic plan_row_t config_row(logic [fcdpr_pkg::INTERVAL_W-1:0] open_v,
                                             logic [fcdpr_pkg::INTERVAL_W-1:0] close_v);
        plan_row_t row;
        row         = tick_row(1'b0, REQ_NONE, '0, '0);
        row.kind    = ROW_CONFIG;
        row.open_v  = open_v;
        row.close_v = close_v;
        return row;
    endfunction

    // Mostly well-formed sequences: time creeps forward, the trigger changes now and then.
    function automatic tick_t next_service_tick(int span);
        tick_t t;
        int    roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            t.enable      = 1'($urandom);
            t.req         = 8'($urandom);
            t.trigger_seq = 8'($urandom);
            t.now_ms      = $urandom;
        end
        else
        begin
            if (roll < 12)
                clock_ms = $urandom;
            else
                clock_ms = clock_ms + $urandom_range(0, span);
            t.enable = ($urandom_range(0, 19) != 0);
            t.req    = 8'($urandom);
            if ($urandom_range(0, 5) == 0)
            begin
                trig_seq = trig_seq + 8'($urandom_range(1, 3));
                if ($urandom_range(0, 7) == 0)
                    t.req = REQ_NONE;
                else
                    t.req = t.req & 8'($urandom);
            end
            t.trigger_seq = trig_seq;
            t.now_ms      = clock_ms;
        end
        return t;
    endfunction

    // Stimulus: reset, the directed table, then the randomised phases.
    initial
    begin : stimulus
        int                               phase;
        int                               i;
        int                               span;
        logic [fcdpr_pkg::INTERVAL_W-1:0] open_v;
        logic [fcdpr_pkg::INTERVAL_W-1:0] close_v;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        drv            = '0;
        drv_known      = 1'b0;
        drv_want       = '0;
        cfg_valid      = 1'b0;
        cfg_index      = fcdpr_pkg::CFG_OPEN_IDX;
        cfg_data       = '0;
        no_idle        = 1'b0;
        holdoff_cycles = 0;
        fail_count     = 0;
        tick_count     = 0;
        result_count   = 0;
        cfg_count      = 0;
        holdoff_count  = 0;
        trig_seq       = '0;
        clock_ms       = '0;
        model_open      = fcdpr_pkg::OPEN_RESET;
        model_close     = fcdpr_pkg::CLOSE_RESET;
        model_last_trig = '0;
        model_pins      = '0;
        for (i = 0; i < fcdpr_pkg::NUM_CH; i++)
        begin
            model_phase[i] = CH_IDLE;
            model_start[i] = '0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: gating, trigger handling, full sequences, wrap and extremes.
        plan.push_back(known_row(1'b0, REQ_ALL,   8'h00, 32'd0,    4'b0000, 4'b0000));
        plan.push_back(known_row(1'b1, REQ_FRONT, 8'h00, 32'd0,    4'b0000, 4'b0000));
        plan.push_back(known_row(1'b0, REQ_ALL,   8'h01, 32'd5,    4'b0000, 4'b0000));
        plan.push_back(known_row(1'b1, REQ_FRONT, 8'h01, 32'd1000, 4'b0011, 4'b0011));
        plan.push_back(tick_row (1'b1, REQ_REAR,  8'h01, 32'd1050));
        plan.push_back(tick_row (1'b1, REQ_NONE,  8'h01, 32'd1100));
        plan.push_back(tick_row (1'b1, REQ_NONE,  8'h01, 32'd1199));
        plan.push_back(tick_row (1'b1, REQ_NONE,  8'h01, 32'd1200));
        plan.push_back(tick_row (1'b0, REQ_NONE,  8'h01, 32'd5000));
        plan.push_back(tick_row (1'b1, REQ_NONE,  8'h01, 32'd1300));
        plan.push_back(known_row(1'b1, REQ_REAR,  8'h02, 32'hFFFF_FFF0, 4'b1100, 4'b1100));
        plan.push_back(tick_row (1'b1, REQ_NONE,  8'h02, 32'h0000_0054));
        plan.push_back(tick_row (1'b1, REQ_LEFT,  8'h03, 32'h0000_0060));
        plan.push_back(tick_row (1'b1, REQ_RIGHT, 8'h04, 32'h0000_0070));
        plan.push_back(tick_row (1'b1, REQ_CH1,   8'h05, 32'h0000_0080));
        plan.push_back(tick_row (1'b1, REQ_CH2,   8'h06, 32'h0000_0090));
        plan.push_back(tick_row (1'b1, REQ_CH3,   8'h07, 32'h0000_00A0));
        plan.push_back(tick_row (1'b1, REQ_CH4,   8'h08, 32'h0000_00B0));
        plan.push_back(known_row(1'b1, REQ_ALL,   8'hFF, 32'hFFFF_FFFF, 4'b1111, 4'b1111));
        plan.push_back(tick_row (1'b1, REQ_NONE,  8'hFF, 32'd0));
        plan.push_back(config_row(16'd0, 16'd0));
        plan.push_back(tick_row (1'b1, REQ_CH1,   8'h00, 32'd10));
        plan.push_back(tick_row (1'b1, REQ_NONE,  8'h00, 32'd10));
        plan.push_back(tick_row (1'b1, REQ_NONE,  8'h00, 32'd10));
        plan.push_back(tick_row (1'b1, REQ_NONE,  8'h00, 32'd10));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CONFIG)
            begin
                wait_for_results(DRAIN_LIMIT);
                write_intervals(plan[i].open_v, plan[i].close_v);
            end
            else
            begin
                offer_tick(plan[i].tick, plan[i].known, plan[i].want_res);
            end
        end

        // Randomised phases, each under its own interval setting.
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    open_v  = 16'd1;
                    close_v = 16'd1;
                end
                1:
                begin
                    open_v  = 16'hFFFF;
                    close_v = 16'hFFFF;
                end
                2:
                begin
                    open_v  = 16'd0;
                    close_v = 16'd0;
                end
                3:
                begin
                    open_v  = 16'd0;
                    close_v = 16'hFFFF;
                end
                4:
                begin
                    open_v  = 16'hFFFF;
                    close_v = 16'd0;
                end
                5:
                begin
                    open_v  = 16'($urandom_range(2, 40));
                    close_v = 16'($urandom_range(2, 40));
                end
                6:
                begin
                    open_v  = 16'($urandom);
                    close_v = 16'($urandom);
                end
                default:
                begin
                    open_v  = fcdpr_pkg::OPEN_RESET;
                    close_v = fcdpr_pkg::CLOSE_RESET;
                end
            endcase
            // The sender pauses here until every result of the last phase has come back or the drain limit runs out.
            wait_for_results(DRAIN_LIMIT);
            write_intervals(open_v, close_v);
            span     = 1 + ((open_v > close_v) ? open_v : close_v) / 3;
            clock_ms = (phase == 1) ? 32'hFFFF_FF00 : $urandom;
            no_idle  = (phase == 2);
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Long receiver hold-off while ticks keep coming, so the input stalls.
                if (phase == 5 && i == 40)
                    holdoff_cycles = HOLDOFF_CYCLES;
                offer_tick(next_service_tick(span), 1'b0, '0);
            end
            no_idle = 1'b0;
        end

        wait_for_results(DRAIN_LIMIT);
        while (pending_pin_states.size() != 0)
        begin
            report_mismatch("expected result never arrived", 32'd0,
                            32'(pending_pin_states.pop_front()));
        end

        $display("Run covered %0d tick transactions and %0d results over %0d register writes,",
                 tick_count, result_count, cfg_count);
        $display("including %0d long receiver hold-off(s); %0d mismatch(es) seen.",
                 holdoff_count, fail_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
hdl/fcdpr_pkg.sv
hdl/fcdpr_channel.sv
hdl/fcdpr_out_buf.sv
hdl/four_channel_double_pulse_release.sv
dv/four_channel_double_pulse_release_test.sv
